FILE: src/circular_motion_generator_top_defines.svh
// ----------------------------------------------------------------------------
// circular motion generator assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_MOTION_GENERATOR_TOP_DEFINES_SVH
`define CIRCULAR_MOTION_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define CMG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cmg assertion failed");

`define CMG_ASSERT_NEXT(label, clk, rst, cond, nxt) \
   `CMG_ASSERT(label, clk, rst, (cond) |=> (nxt))

`else

`define CMG_ASSERT(label, clk, rst, prop)

`define CMG_ASSERT_NEXT(label, clk, rst, cond, nxt)

`endif

`endif

FILE: src/cmg_pkg.sv
// ----------------------------------------------------------------------------
// cmg_pkg
// shared widths, register indexes, constants and the cordic angle table
// ----------------------------------------------------------------------------
package cmg_pkg;

   localparam int PHASE_BITS_DEFAULT   = 32;
   localparam int CORDIC_STEPS_DEFAULT = 16;

   localparam int PHASE32_W  = 32;
   localparam int XY_W       = 33;
   localparam int Z_W        = 32;
   localparam int TRIG_W     = 18;
   localparam int TRIG_SHIFT = 14;
   localparam int RADIUS_W   = 31;
   localparam int COORD_W    = 32;
   localparam int PROD_W     = RADIUS_W + 1 + TRIG_W;
   localparam int PROD_SHIFT = 16;
   localparam int ANGLE_W    = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;

   localparam int DEG_MULT_W = 6;
   localparam int DEG_SHIFT  = 22;
   localparam logic [DEG_MULT_W-1:0] DEG_MULT = 6'd45;

   localparam logic [XY_W-1:0] CORDIC_GAIN = 33'd652032874;
   localparam logic [XY_W:0] TRIG_ROUND    = 34'd8192;
   localparam logic [PROD_W-1:0] PROD_ROUND = 50'd32768;

   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_X   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_Y   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_Z   = 3'd4;

   typedef struct packed {
      logic            valid;
      logic [XY_W-1:0] x;
      logic [XY_W-1:0] y;
      logic [Z_W-1:0]  z;
   } cmg_rot_type;

   // atan(2^-i) as a fraction of a turn scaled by 2^32
   function automatic logic [Z_W-1:0] cmg_atan(input int unsigned step);
      logic [Z_W-1:0] a;
      case (step)
         0:  a = 32'h20000000;
         1:  a = 32'h12E4051E;
         2:  a = 32'h09FB385B;
         3:  a = 32'h051111D4;
         4:  a = 32'h028B0D43;
         5:  a = 32'h0145D7E1;
         6:  a = 32'h00A2F61E;
         7:  a = 32'h00517C55;
         8:  a = 32'h0028BE53;
         9:  a = 32'h00145F2F;
         10: a = 32'h000A2F98;
         11: a = 32'h000517CC;
         12: a = 32'h00028BE6;
         13: a = 32'h000145F3;
         14: a = 32'h0000A2FA;
         15: a = 32'h0000517D;
         16: a = 32'h000028BE;
         17: a = 32'h0000145F;
         18: a = 32'h00000A30;
         19: a = 32'h00000518;
         20: a = 32'h0000028C;
         21: a = 32'h00000146;
         22: a = 32'h000000A3;
         23: a = 32'h00000051;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

FILE: src/cmg_cordic_cell.sv
// ----------------------------------------------------------------------------
// cmg_cordic_cell
// one rotation-mode cordic micro-rotation with its output register
// ----------------------------------------------------------------------------
module cmg_cordic_cell import cmg_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  cmg_rot_type rot_in,
   output cmg_rot_type rot_out
);

   localparam logic [Z_W-1:0] ATAN = cmg_atan(STEP);

   logic            valid_ff;
   logic [XY_W-1:0] x_ff, x_in;
   logic [XY_W-1:0] y_ff, y_in;
   logic [Z_W-1:0]  z_ff, z_in;
   logic [XY_W-1:0] dx, dy;

   always_comb begin
      dx = $signed(rot_in.y) >>> STEP;
      dy = $signed(rot_in.x) >>> STEP;
      if (!rot_in.z[Z_W-1]) begin
         x_in = rot_in.x - dx;
         y_in = rot_in.y + dy;
         z_in = rot_in.z - ATAN;
      end else begin
         x_in = rot_in.x + dx;
         y_in = rot_in.y - dy;
         z_in = rot_in.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= rot_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign rot_out = '{valid: valid_ff, x: x_ff, y: y_ff, z: z_ff};

endmodule

FILE: src/cmg_cordic_chain.sv
// ----------------------------------------------------------------------------
// cmg_cordic_chain
// row of cordic cells, an item moves one cell per cycle
// ----------------------------------------------------------------------------
`include "circular_motion_generator_top_defines.svh"

module cmg_cordic_chain import cmg_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cmg_rot_type rot_in,
   output cmg_rot_type rot_out
);

   cmg_rot_type             link [CORDIC_STEPS+1];
   logic [CORDIC_STEPS:0]   valid_vec;

   assign link[0] = rot_in;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      cmg_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .rot_in  (link[i]),
         .rot_out (link[i+1])
      );
   end

   for (genvar i = 0; i <= CORDIC_STEPS; i++) begin : g_valid
      assign valid_vec[i] = link[i].valid;
   end

   assign rot_out = link[CORDIC_STEPS];

   `CMG_ASSERT(a_chain_single_item, clock, reset, $onehot0(valid_vec))
   `CMG_ASSERT(a_chain_latency, clock, reset, rot_out.valid |-> $past(rot_in.valid, CORDIC_STEPS))
   `CMG_ASSERT_NEXT(a_chain_no_bypass, clock, reset, rot_in.valid, !rot_out.valid)

endmodule

FILE: src/cmg_output_stage.sv
// ----------------------------------------------------------------------------
// cmg_output_stage
// quadrant fold and rounding, radius scaling, center add with saturation
// ----------------------------------------------------------------------------
module cmg_output_stage import cmg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmg_rot_type         rot_in,
   input  logic [1:0]          quad,
   input  logic [RADIUS_W-1:0] radius,
   input  logic [COORD_W-1:0]  center_x,
   input  logic [COORD_W-1:0]  center_y,
   input  logic [COORD_W-1:0]  center_z,
   input  logic [ANGLE_W-1:0]  angle,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [COORD_W-1:0]  rsp_pos_x,
   output logic [COORD_W-1:0]  rsp_pos_y,
   output logic [COORD_W-1:0]  rsp_pos_z,
   output logic [ANGLE_W-1:0]  rsp_angle_deg
);

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;

   localparam logic signed [COORD_W:0] SAT_MAX = 33'sh0_7FFF_FFFF;
   localparam logic signed [COORD_W:0] SAT_MIN = -33'sh0_8000_0000;

   logic                va_ff, vb_ff, rsp_valid_ff, rsp_valid_in;
   logic [XY_W-1:0]     c_sel, s_sel;
   logic [XY_W:0]       c_rnd, s_rnd;
   logic [TRIG_W-1:0]   cos_ff, sin_ff;
   logic [PROD_W-1:0]   prod_x_ff, prod_z_ff, prod_x_in, prod_z_in;
   logic [PROD_W-1:0]   px_rnd, pz_rnd;
   logic [COORD_W+2:0]  sum_x, sum_z;
   logic [COORD_W-1:0]  pos_x_ff, pos_x_in, pos_z_ff, pos_z_in;
   logic [COORD_W-1:0]  pos_y_ff;
   logic [ANGLE_W-1:0]  angle_ff;

   function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W+2:0] v);
      logic [COORD_W-1:0] r;
      if ($signed(v) > SAT_MAX) begin
         r = SAT_MAX[COORD_W-1:0];
      end else if ($signed(v) < SAT_MIN) begin
         r = SAT_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   // quadrant fold, then round q2.30 to q1.16
   always_comb begin
      case (quad)
         QUAD_FIRST: begin
            c_sel = rot_in.x;
            s_sel = rot_in.y;
         end
         QUAD_SECOND: begin
            c_sel = -rot_in.y;
            s_sel = rot_in.x;
         end
         QUAD_THIRD: begin
            c_sel = -rot_in.x;
            s_sel = -rot_in.y;
         end
         default: begin
            c_sel = rot_in.y;
            s_sel = -rot_in.x;
         end
      endcase
      c_rnd = {c_sel[XY_W-1], c_sel} + TRIG_ROUND;
      s_rnd = {s_sel[XY_W-1], s_sel} + TRIG_ROUND;
   end

   assign prod_x_in = PROD_W'($signed({1'b0, radius}) * $signed(cos_ff));
   assign prod_z_in = PROD_W'($signed({1'b0, radius}) * $signed(sin_ff));

   always_comb begin
      px_rnd   = prod_x_ff + PROD_ROUND;
      pz_rnd   = prod_z_ff + PROD_ROUND;
      sum_x    = (COORD_W+3)'($signed(px_rnd[PROD_W-1:PROD_SHIFT]))
               + (COORD_W+3)'($signed(center_x));
      sum_z    = (COORD_W+3)'($signed(pz_rnd[PROD_W-1:PROD_SHIFT]))
               + (COORD_W+3)'($signed(center_z));
      pos_x_in = sat_coord(sum_x);
      pos_z_in = sat_coord(sum_z);
   end

   assign rsp_valid_in = vb_ff | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         va_ff        <= rot_in.valid;
         vb_ff        <= va_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rot_in.valid) begin
         cos_ff <= c_rnd[TRIG_SHIFT+TRIG_W-1:TRIG_SHIFT];
         sin_ff <= s_rnd[TRIG_SHIFT+TRIG_W-1:TRIG_SHIFT];
      end
      if (va_ff) begin
         prod_x_ff <= prod_x_in;
         prod_z_ff <= prod_z_in;
      end
      if (vb_ff) begin
         pos_x_ff <= pos_x_in;
         pos_z_ff <= pos_z_in;
         pos_y_ff <= center_y;
         angle_ff <= angle;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = pos_x_ff;
   assign rsp_pos_y     = pos_y_ff;
   assign rsp_pos_z     = pos_z_ff;
   assign rsp_angle_deg = angle_ff;

endmodule

FILE: src/circular_motion_generator_top.sv
// one item at a time: after an item is accepted, req_stall stays high until its response is accepted
// an item passes through the cordic cell chain and then three output stages to rsp_valid
// reset: synchronous, active high; clears phase, configuration registers and all valid flags
// ----------------------------------------------------------------------------
// circular_motion_generator_top
// phase accumulator feeding a cordic cell chain, outputs a point on a circle
// ----------------------------------------------------------------------------
`include "circular_motion_generator_top_defines.svh"

module circular_motion_generator_top import cmg_pkg::*; #(
   parameter int PHASE_BITS   = PHASE_BITS_DEFAULT,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_advance,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_W-1:0]     rsp_pos_x,
   output logic [COORD_W-1:0]     rsp_pos_y,
   output logic [COORD_W-1:0]     rsp_pos_z,
   output logic [ANGLE_W-1:0]     rsp_angle_deg
);

   localparam int DEG_PROD_W = PHASE32_W + DEG_MULT_W;

   logic [PHASE32_W-1:0]  phase_step_ff;
   logic [RADIUS_W-1:0]   radius_ff;
   logic [COORD_W-1:0]    center_x_ff, center_y_ff, center_z_ff;
   logic [PHASE_BITS-1:0] phase_acc_ff, phase_acc_in;
   logic [1:0]            quad_ff;
   logic [ANGLE_W-1:0]    angle_ff;
   logic                  busy_ff, busy_in;
   logic                  req_accept, rsp_accept;
   logic [PHASE32_W-1:0]  phase32;
   logic [DEG_PROD_W-1:0] deg_prod;
   cmg_rot_type           rot_start, rot_end;

   assign req_accept = req_valid & ~busy_ff;
   assign rsp_accept = rsp_valid & ~rsp_stall;
   assign req_stall  = busy_ff;

   always_comb begin
      phase_acc_in = phase_acc_ff;
      if (req_advance) begin
         phase_acc_in = phase_acc_ff + phase_step_ff[PHASE32_W-1 -: PHASE_BITS];
      end
      phase32  = PHASE32_W'(phase_acc_in) << (PHASE32_W - PHASE_BITS);
      deg_prod = DEG_PROD_W'(phase32) * DEG_PROD_W'(DEG_MULT);
      busy_in  = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (rsp_accept) begin
         busy_in = 1'b0;
      end
   end

   assign rot_start = '{valid: req_accept,
                        x:     CORDIC_GAIN,
                        y:     '0,
                        z:     Z_W'(phase32[PHASE32_W-3:0])};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         phase_acc_ff  <= '0;
         phase_step_ff <= '0;
         radius_ff     <= '0;
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         center_z_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         if (req_accept) begin
            phase_acc_ff <= phase_acc_in;
         end
         if (csr_wen) begin
            case (csr_index)
               REG_PHASE_STEP: phase_step_ff <= csr_wdata;
               REG_RADIUS:     radius_ff     <= csr_wdata[RADIUS_W-1:0];
               REG_CENTER_X:   center_x_ff   <= csr_wdata;
               REG_CENTER_Y:   center_y_ff   <= csr_wdata;
               REG_CENTER_Z:   center_z_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         quad_ff  <= phase32[PHASE32_W-1 -: 2];
         angle_ff <= deg_prod[DEG_SHIFT +: ANGLE_W];
      end
   end

   cmg_cordic_chain #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .rot_in  (rot_start),
      .rot_out (rot_end)
   );

   cmg_output_stage u_out (
      .clock         (clock),
      .reset         (reset),
      .rot_in        (rot_end),
      .quad          (quad_ff),
      .radius        (radius_ff),
      .center_x      (center_x_ff),
      .center_y      (center_y_ff),
      .center_z      (center_z_ff),
      .angle         (angle_ff),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_angle_deg (rsp_angle_deg)
   );

   `CMG_ASSERT_NEXT(a_one_rsp_per_item, clock, reset, rsp_valid && !rsp_stall, !rsp_valid)
   `CMG_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && !req_stall, !rsp_valid)
   `CMG_ASSERT(a_rsp_while_busy, clock, reset, rsp_valid |-> req_stall)

endmodule
